@@ rtl/grid_snap_quantizer_assert.svh @@
// Assertion macros for the grid snap quantizer top level.
`ifndef GRID_SNAP_QUANTIZER_ASSERT_SVH
`define GRID_SNAP_QUANTIZER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define GSQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid snap quantizer: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define GSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid snap quantizer: next-cycle check failed");

`endif

@@ rtl/gsq_pkg.sv @@
package gsq_pkg;

   localparam int PT_W       = 20;
   localparam int FRAC_BITS  = 4;
   localparam int STEP_W     = 9;
   localparam int SCR_W      = 13;
   localparam int VIEW_W     = 32;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 3;
   localparam int MAX_STEP   = 256;
   localparam int MAX_SCREEN = 4096;

   localparam int KW        = $clog2(MAX_SCREEN);
   localparam int QD_W      = PT_W - 1 - FRAC_BITS;
   localparam int QA_STEPS  = 8;
   localparam int REM_STEPS = 8;
   localparam int REM_STG   = VIEW_W / REM_STEPS;
   localparam int NSTG      = REM_STG + 6;

   localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(2);

   localparam logic              RST_SNAP_ENABLE = 1'b1;
   localparam logic [STEP_W-1:0] RST_GRID_STEP   = STEP_W'(48);
   localparam logic [VIEW_W-1:0] RST_VIEW        = '0;
   localparam logic [SCR_W-1:0]  RST_SCREEN_W    = SCR_W'(800);
   localparam logic [SCR_W-1:0]  RST_SCREEN_H    = SCR_W'(600);

   typedef enum logic [IDX_W-1:0] {
      CSR_SNAP_ENABLE = 3'd0,
      CSR_GRID_STEP   = 3'd1,
      CSR_VIEW_X      = 3'd2,
      CSR_VIEW_Y      = 3'd3,
      CSR_SCREEN_W    = 3'd4,
      CSR_SCREEN_H    = 3'd5
   } gsq_csr_type;

   typedef struct packed {
      logic signed [PT_W-1:0] point_x;
      logic signed [PT_W-1:0] point_y;
   } gsq_req_type;

   typedef struct packed {
      logic signed [PT_W-1:0] snap_x;
      logic signed [PT_W-1:0] snap_y;
      logic                   was_snapped;
   } gsq_rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0]        step;
      logic signed [VIEW_W-1:0] view;
      logic [SCR_W-1:0]         screen;
   } gsq_axis_cfg_type;

endpackage

@@ rtl/gsq_axis.sv @@
module gsq_axis
   import gsq_pkg::*;
(
   input  logic                   clock,
   input  logic [NSTG-1:0]        load,
   input  gsq_axis_cfg_type       cfg,
   input  logic                   bypass,
   input  logic signed [PT_W-1:0] point,
   output logic signed [PT_W-1:0] snap
);

   localparam int ST_ORG = REM_STG + 1;
   localparam int ST_DA  = REM_STG + 2;
   localparam int ST_DB  = REM_STG + 3;
   localparam int ST_RND = REM_STG + 4;
   localparam int ST_OUT = REM_STG + 5;
   localparam int LW     = STEP_W + FRAC_BITS + 1;
   localparam int PW     = KW + STEP_W;

   function automatic logic [STEP_W:0] div_step(input logic [STEP_W-1:0] rem,
                                                input logic din,
                                                input logic [STEP_W-1:0] dvs);
      logic [STEP_W:0] t;
      logic [STEP_W:0] d;
      t = {rem, din};
      d = t - {1'b0, dvs};
      if (t >= {1'b0, dvs}) begin
         div_step = {1'b1, d[STEP_W-1:0]};
      end else begin
         div_step = {1'b0, t[STEP_W-1:0]};
      end
   endfunction

   logic [PT_W-1:0]   pt_ff  [0:ST_RND];
   logic              byp_ff [0:ST_RND];
   logic [VIEW_W-1:0] mag_ff [0:REM_STG];
   logic              neg_ff [0:REM_STG];
   logic [STEP_W-1:0] rem_ff [1:REM_STG];
   logic [VIEW_W-1:0] mag_in;

   // sign-magnitude split of the view position
   always_comb begin
      mag_in = cfg.view[VIEW_W-1] ? (~cfg.view + 1'b1) : cfg.view;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         mag_ff[0] <= mag_in;
         neg_ff[0] <= cfg.view[VIEW_W-1];
         pt_ff[0]  <= point;
         byp_ff[0] <= bypass;
      end
   end

   for (genvar i = 1; i <= ST_RND; i++) begin : g_carry
      always_ff @(posedge clock) begin
         if (load[i]) begin
            pt_ff[i]  <= pt_ff[i-1];
            byp_ff[i] <= byp_ff[i-1];
         end
      end
   end

   // view magnitude modulo step, REM_STEPS bits per stage
   for (genvar j = 1; j <= REM_STG; j++) begin : g_rem
      logic [STEP_W-1:0] rem_start;
      logic [STEP_W-1:0] rem_in;

      if (j == 1) begin : g_first
         assign rem_start = '0;
      end else begin : g_next
         assign rem_start = rem_ff[j-1];
      end

      always_comb begin
         logic [STEP_W:0] t;
         rem_in = rem_start;
         for (int b = 0; b < REM_STEPS; b++) begin
            t      = div_step(rem_in, mag_ff[j-1][VIEW_W-1-(j-1)*REM_STEPS-b], cfg.step);
            rem_in = t[STEP_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (load[j]) begin
            rem_ff[j] <= rem_in;
            mag_ff[j] <= mag_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   // origin, offset from origin and room left on screen
   logic [STEP_W-1:0] org_ff,   org_in;
   logic [QD_W-1:0]   dhi_ff,   dhi_in;
   logic [FRAC_BITS-1:0] dfr_ff, dfr_in;
   logic              dpos_ff,  dpos_in;
   logic [KW-1:0]     lim_ff,   lim_in;
   logic              onscr_ff, onscr_in;

   always_comb begin
      logic [STEP_W-1:0] rem;
      logic [PT_W:0]     d;
      logic [SCR_W-1:0]  room;
      rem      = rem_ff[REM_STG];
      org_in   = (neg_ff[REM_STG] && (rem != '0)) ? (cfg.step - rem) : rem;
      d        = {pt_ff[REM_STG][PT_W-1], pt_ff[REM_STG]}
                 - {{(PT_W+1-STEP_W-FRAC_BITS){1'b0}}, org_in, {FRAC_BITS{1'b0}}};
      dpos_in  = !d[PT_W] && (d != '0);
      dhi_in   = d[PT_W-2:FRAC_BITS];
      dfr_in   = d[FRAC_BITS-1:0];
      onscr_in = SCR_W'(org_in) < cfg.screen;
      room     = cfg.screen - SCR_W'(1) - SCR_W'(org_in);
      lim_in   = room[KW-1:0];
   end

   always_ff @(posedge clock) begin
      if (load[ST_ORG]) begin
         org_ff   <= org_in;
         dhi_ff   <= dhi_in;
         dfr_ff   <= dfr_in;
         dpos_ff  <= dpos_in;
         lim_ff   <= lim_in;
         onscr_ff <= onscr_in;
      end
   end

   // quotients of offset and room by step, upper bits
   logic [QD_W-1:0]      dha_ff;
   logic [KW-1:0]        lma_ff;
   logic [QD_W-1:0]      qda_ff,  qda_in;
   logic [STEP_W-1:0]    rda_ff,  rda_in;
   logic [QD_W-1:0]      qla_ff,  qla_in;
   logic [STEP_W-1:0]    rla_ff,  rla_in;
   logic [STEP_W-1:0]    orga_ff;
   logic [FRAC_BITS-1:0] dfra_ff;
   logic                 dposa_ff;
   logic                 onscra_ff;

   always_comb begin
      logic [STEP_W:0] t;
      logic [QD_W-1:0] lx;
      lx     = QD_W'(lim_ff);
      qda_in = '0;
      qla_in = '0;
      rda_in = '0;
      rla_in = '0;
      for (int b = 0; b < QA_STEPS; b++) begin
         t                   = div_step(rda_in, dhi_ff[QD_W-1-b], cfg.step);
         qda_in[QD_W-1-b]    = t[STEP_W];
         rda_in              = t[STEP_W-1:0];
         t                   = div_step(rla_in, lx[QD_W-1-b], cfg.step);
         qla_in[QD_W-1-b]    = t[STEP_W];
         rla_in              = t[STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_DA]) begin
         dha_ff    <= dhi_ff;
         lma_ff    <= lim_ff;
         qda_ff    <= qda_in;
         rda_ff    <= rda_in;
         qla_ff    <= qla_in;
         rla_ff    <= rla_in;
         orga_ff   <= org_ff;
         dfra_ff   <= dfr_ff;
         dposa_ff  <= dpos_ff;
         onscra_ff <= onscr_ff;
      end
   end

   // quotients, lower bits
   logic [QD_W-1:0]      qdb_ff,  qdb_in;
   logic [STEP_W-1:0]    rdb_ff,  rdb_in;
   logic [QD_W-1:0]      qlb_ff,  qlb_in;
   logic [STEP_W-1:0]    orgb_ff;
   logic [FRAC_BITS-1:0] dfrb_ff;
   logic                 dposb_ff;
   logic                 onscrb_ff;

   always_comb begin
      logic [STEP_W:0]   t;
      logic [QD_W-1:0]   lx;
      logic [STEP_W-1:0] rl;
      lx     = QD_W'(lma_ff);
      qdb_in = qda_ff;
      qlb_in = qla_ff;
      rdb_in = rda_ff;
      rl     = rla_ff;
      for (int b = QA_STEPS; b < QD_W; b++) begin
         t                = div_step(rdb_in, dha_ff[QD_W-1-b], cfg.step);
         qdb_in[QD_W-1-b] = t[STEP_W];
         rdb_in           = t[STEP_W-1:0];
         t                = div_step(rl, lx[QD_W-1-b], cfg.step);
         qlb_in[QD_W-1-b] = t[STEP_W];
         rl               = t[STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_DB]) begin
         qdb_ff    <= qdb_in;
         rdb_ff    <= rdb_in;
         qlb_ff    <= qlb_in;
         orgb_ff   <= orga_ff;
         dfrb_ff   <= dfra_ff;
         dposb_ff  <= dposa_ff;
         onscrb_ff <= onscra_ff;
      end
   end

   // round to nearest, tie low, clamp to last visible line
   logic [KW-1:0]     k_ff,    k_in;
   logic [STEP_W-1:0] orgr_ff;

   always_comb begin
      logic [LW-1:0]   lhs;
      logic [LW-1:0]   rhs;
      logic [QD_W:0]   kr;
      logic [KW-1:0]   kmax;
      lhs  = {rdb_ff, {(FRAC_BITS+1){1'b0}}} + LW'({dfrb_ff, 1'b0});
      rhs  = LW'({cfg.step, {FRAC_BITS{1'b0}}});
      kr   = {1'b0, qdb_ff} + (QD_W+1)'(lhs > rhs);
      kmax = onscrb_ff ? qlb_ff[KW-1:0] : '0;
      if (!dposb_ff) begin
         k_in = '0;
      end else if (kr > (QD_W+1)'(kmax)) begin
         k_in = kmax;
      end else begin
         k_in = kr[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_RND]) begin
         k_ff    <= k_in;
         orgr_ff <= orgb_ff;
      end
   end

   // grid coordinate back to fixed point
   logic [PT_W-1:0] res_ff, res_in;

   always_comb begin
      logic [PW-1:0] pos;
      pos    = k_ff * cfg.step + PW'(orgr_ff);
      res_in = byp_ff[ST_RND] ? pt_ff[ST_RND]
                              : {pos[PT_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (load[ST_OUT]) begin
         res_ff <= res_in;
      end
   end

   assign snap = res_ff;

endmodule

@@ rtl/grid_snap_quantizer.sv @@
// Grid snap quantizer: moves a point in 1/16-pixel fixed point to the nearest
// visible grid point, each axis on its own; the grid origin is the view
// position modulo the step, grid points lie below the screen size.
// Input channel req_*: one point per item. Result channel rsp_*: one snapped
// point per item, in order; was_snapped is low if snapping is off or step < 2.
// Configuration: csr_write with csr_index and csr_wdata writes one register;
// write only while no item is in flight.
// Throughput: one item per cycle while rsp_stall is low. Each item passes
// through ten register stages: an input stage that splits off the view sign,
// four stages of the 32-bit view-modulo-step recurrence (8 bits each), one
// origin stage, two stages of the 15-bit offset and room quotients, one
// rounding stage and the multiply-add output register.
// Reset clears all stage valid bits and loads the register defaults.
// When rsp_stall is high the output item holds; empty stages still fill, and
// req_stall rises only once all ten stages hold items.
`include "grid_snap_quantizer_assert.svh"

module grid_snap_quantizer
   import gsq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gsq_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gsq_rsp_type       rsp_data,
   input  logic              csr_write,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);

   logic              snap_enable_ff;
   logic [STEP_W-1:0] grid_step_ff;
   logic [VIEW_W-1:0] view_x_ff;
   logic [VIEW_W-1:0] view_y_ff;
   logic [SCR_W-1:0]  screen_w_ff;
   logic [SCR_W-1:0]  screen_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_enable_ff <= RST_SNAP_ENABLE;
         grid_step_ff   <= RST_GRID_STEP;
         view_x_ff      <= RST_VIEW;
         view_y_ff      <= RST_VIEW;
         screen_w_ff    <= RST_SCREEN_W;
         screen_h_ff    <= RST_SCREEN_H;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SNAP_ENABLE: snap_enable_ff <= csr_wdata[0];
            CSR_GRID_STEP:   grid_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_VIEW_X:      view_x_ff      <= csr_wdata[VIEW_W-1:0];
            CSR_VIEW_Y:      view_y_ff      <= csr_wdata[VIEW_W-1:0];
            CSR_SCREEN_W:    screen_w_ff    <= csr_wdata[SCR_W-1:0];
            CSR_SCREEN_H:    screen_h_ff    <= csr_wdata[SCR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   logic [STEP_W-1:0] step_sat;
   logic [SCR_W-1:0]  scr_w_sat;
   logic [SCR_W-1:0]  scr_h_sat;
   logic              bypass;
   gsq_axis_cfg_type  cfg_x;
   gsq_axis_cfg_type  cfg_y;

   always_comb begin
      step_sat  = (grid_step_ff > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : grid_step_ff;
      scr_w_sat = (screen_w_ff > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : screen_w_ff;
      scr_h_sat = (screen_h_ff > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : screen_h_ff;
      bypass    = !snap_enable_ff || (grid_step_ff < MIN_STEP);
      cfg_x     = '{step: step_sat, view: view_x_ff, screen: scr_w_sat};
      cfg_y     = '{step: step_sat, view: view_y_ff, screen: scr_h_sat};
   end

   // stage control: a stage loads when it is empty or its successor moves
   logic [NSTG-1:0] stg_valid_ff, stg_valid_in;
   logic [NSTG-1:0] load;
   logic [NSTG-1:0] snp_ff;

   always_comb begin
      load[NSTG-1] = !stg_valid_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         load[i] = !stg_valid_ff[i] || load[i+1];
      end
      stg_valid_in = stg_valid_ff;
      if (load[0]) begin
         stg_valid_in[0] = req_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
         if (load[i]) begin
            stg_valid_in[i] = stg_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         snp_ff[0] <= !bypass;
      end
      for (int i = 1; i < NSTG; i++) begin
         if (load[i]) begin
            snp_ff[i] <= snp_ff[i-1];
         end
      end
   end

   logic signed [PT_W-1:0] snap_x;
   logic signed [PT_W-1:0] snap_y;

   gsq_axis u_axis_x (
      .clock  (clock),
      .load   (load),
      .cfg    (cfg_x),
      .bypass (bypass),
      .point  (req_data.point_x),
      .snap   (snap_x)
   );

   gsq_axis u_axis_y (
      .clock  (clock),
      .load   (load),
      .cfg    (cfg_y),
      .bypass (bypass),
      .point  (req_data.point_y),
      .snap   (snap_y)
   );

   assign req_stall            = !load[0];
   assign rsp_valid            = stg_valid_ff[NSTG-1];
   assign rsp_data.snap_x      = snap_x;
   assign rsp_data.snap_y      = snap_y;
   assign rsp_data.was_snapped = snp_ff[NSTG-1];

   `GSQ_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
                   (&stg_valid_ff) && rsp_stall)
   `GSQ_ASSERT_NEXT(a_empty_stays_empty, clock, reset,
                    !(|stg_valid_ff) && !req_valid, !(|stg_valid_ff))
   `GSQ_ASSERT_NOW(a_snap_on_whole_pixel, clock, reset,
                   rsp_valid && rsp_data.was_snapped,
                   (rsp_data.snap_x[FRAC_BITS-1:0] == '0)
                   && (rsp_data.snap_y[FRAC_BITS-1:0] == '0))

endmodule
